// ===== design/postfix_expression_evaluator_macros.svh =====
// Assertion macros used by the postfix evaluator design file.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_MACROS_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_MACROS_SVH

// Same-cycle implication, checked outside reset
`define PFE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define PFE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/pfe_pkg.sv =====
// Shared constants, types and codes for the postfix expression evaluator.
package pfe_pkg;

    // Sizing
    localparam int STACK_DEPTH = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int SYM_W       = 8;
    localparam int STATUS_W    = 3;
    localparam int IN_TDATA_W  = ((SYM_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((VALUE_WIDTH + STATUS_W + 7) / 8) * 8;

    // Character codes
    localparam logic [SYM_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [SYM_W-1:0] CH_NINE  = 8'h39;
    localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] CH_MUL   = 8'h2A;
    localparam logic [SYM_W-1:0] CH_DIV   = 8'h2F;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_UNDER   = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVER    = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_DIVZERO = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 3'd4;

    typedef logic [VALUE_WIDTH-1:0] t_value;

    // What one stack cell loads this cycle
    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,   // keep own entry
        CELL_UP   = 2'd1,   // take the entry above (push)
        CELL_D1   = 2'd2,   // take the entry one below
        CELL_D2   = 2'd3    // take the entry two below
    } t_cell_cmd;

    // Whole-stack moves
    typedef enum logic [1:0] {
        OP_HOLD     = 2'd0,
        OP_PUSH     = 2'd1,
        OP_POP_REPL = 2'd2,  // pop two, push one result
        OP_POP2     = 2'd3
    } t_stack_op;

    // Divider request and response
    typedef struct packed {
        logic   start;
        t_value dividend;   // magnitude
        t_value divisor;    // magnitude, nonzero
        logic   negate;
    } t_div_req;

    typedef struct packed {
        logic   busy;
        logic   done;
        t_value quotient;   // signed, valid with done
    } t_div_rsp;

endpackage

// ===== design/pfe_cell.sv =====
// One operand stack cell: holds an entry and shifts with its neighbours.
module pfe_cell (
    input  logic              i_clk,
    input  pfe_pkg::t_cell_cmd i_cmd,
    input  pfe_pkg::t_value   i_up,
    input  pfe_pkg::t_value   i_down1,
    input  pfe_pkg::t_value   i_down2,
    output pfe_pkg::t_value   o_value
);
    import pfe_pkg::*;

    t_value r_value;
    t_value n_value;

    // Entry select
    always_comb begin
        unique case (i_cmd)
            CELL_HOLD: n_value = r_value;
            CELL_UP:   n_value = i_up;
            CELL_D1:   n_value = i_down1;
            CELL_D2:   n_value = i_down2;
            default:   n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

// ===== design/pfe_divider.sv =====
// Restoring divider, one quotient bit per cycle, with sign fix on the result.
module pfe_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pfe_pkg::t_div_req i_req,
    output pfe_pkg::t_div_rsp o_rsp
);
    import pfe_pkg::*;

    localparam int CNT_W = $clog2(VALUE_WIDTH);

    logic                   r_busy, n_busy;
    logic                   r_done, n_done;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    t_value                 r_rem, n_rem;
    t_value                 r_quo, n_quo;
    t_value                 r_div, n_div;
    logic                   r_neg, n_neg;
    logic [VALUE_WIDTH:0]   w_shift;
    logic                   w_ge;

    // Trial subtract of the shifted remainder
    assign w_shift = {r_rem, r_quo[VALUE_WIDTH-1]};
    assign w_ge    = (w_shift >= {1'b0, r_div});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_div  = r_div;
        n_neg  = r_neg;
        if (i_req.start && !r_busy) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(VALUE_WIDTH - 1);
            n_rem  = '0;
            n_quo  = i_req.dividend;
            n_div  = i_req.divisor;
            n_neg  = i_req.negate;
        end else if (r_busy) begin
            // remainder stays below the divisor, so it fits the value width
            n_rem = w_ge ? t_value'(w_shift - {1'b0, r_div}) : w_shift[VALUE_WIDTH-1:0];
            n_quo = {r_quo[VALUE_WIDTH-2:0], w_ge};
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_div <= n_div;
        r_neg <= n_neg;
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_neg ? (t_value'(0) - r_quo) : r_quo;

endmodule

// ===== design/postfix_expression_evaluator.sv =====
// Postfix evaluator: a digit, '+' or '-' is done when taken, '*' uses a multiply state,
// '/' waits for the serial divider. An item marked last then loads the output register
// in a finish state, waiting while that register is full. A new item is accepted while
// that result waits to be taken, but not while a '*', '/' or last item is in work.
// Synchronous active-low reset empties the stack, clears the status and the output valid.
`include "postfix_expression_evaluator_macros.svh"

module postfix_expression_evaluator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [pfe_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,   // [7:0] symbol
    input  logic                            i_s_axis_tlast,   // last
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [pfe_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata    // [31:0] value, [34:32] status
);
    import pfe_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state                r_state, n_state;
    logic [DEPTH_W-1:0]    r_depth, n_depth;
    logic [STATUS_W-1:0]   r_err, n_err;
    logic                  r_last, n_last;
    logic                  r_out_valid, n_out_valid;
    t_value                r_out_value, n_out_value;
    logic [STATUS_W-1:0]   r_out_status, n_out_status;

    t_stack_op             w_op;
    t_value                w_ins;
    t_value                w_val [STACK_DEPTH];
    t_cell_cmd             w_cmd [STACK_DEPTH];
    t_div_req              w_div_req;
    t_div_rsp              w_div_rsp;
    logic                  w_accept;
    logic                  w_out_free;
    logic [SYM_W-1:0]      w_sym;
    t_value                w_a, w_b;
    t_state                w_after;

    assign w_sym      = i_s_axis_tdata[SYM_W-1:0];
    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !r_out_valid || i_m_axis_tready;
    assign w_a        = w_val[0];
    assign w_b        = w_val[1];

    // Chain of stack cells, cell 0 is the top
    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
        t_value w_up, w_d1, w_d2;

        if (i == 0) begin : g_top
            assign w_up = w_ins;
        end else begin : g_mid
            assign w_up = w_val[i-1];
        end
        if (i + 1 < STACK_DEPTH) begin : g_d1
            assign w_d1 = w_val[i+1];
        end else begin : g_d1_end
            assign w_d1 = '0;
        end
        if (i + 2 < STACK_DEPTH) begin : g_d2
            assign w_d2 = w_val[i+2];
        end else begin : g_d2_end
            assign w_d2 = '0;
        end

        // Map the stack move onto this cell
        always_comb begin
            unique case (w_op)
                OP_HOLD:     w_cmd[i] = CELL_HOLD;
                OP_PUSH:     w_cmd[i] = CELL_UP;
                OP_POP_REPL: w_cmd[i] = (i == 0) ? CELL_UP : CELL_D1;
                OP_POP2:     w_cmd[i] = CELL_D2;
                default:     w_cmd[i] = CELL_HOLD;
            endcase
        end

        pfe_cell u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd[i]),
            .i_up    (w_up),
            .i_down1 (w_d1),
            .i_down2 (w_d2),
            .o_value (w_val[i])
        );
    end

    pfe_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_depth      = r_depth;
        n_err        = r_err;
        n_last       = r_last;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        w_op         = OP_HOLD;
        w_ins        = '0;
        w_after      = r_last ? S_FIN : S_IDLE;

        w_div_req.start    = 1'b0;
        w_div_req.dividend = w_b[VALUE_WIDTH-1] ? (t_value'(0) - w_b) : w_b;
        w_div_req.divisor  = w_a[VALUE_WIDTH-1] ? (t_value'(0) - w_a) : w_a;
        w_div_req.negate   = w_a[VALUE_WIDTH-1] ^ w_b[VALUE_WIDTH-1];

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_last  = i_s_axis_tlast;
                    n_state = i_s_axis_tlast ? S_FIN : S_IDLE;
                    if (r_err == STATUS_OK) begin
                        priority if (w_sym >= CH_ZERO && w_sym <= CH_NINE) begin
                            if (r_depth >= DEPTH_W'(STACK_DEPTH)) begin
                                n_err = STATUS_OVER;
                            end else begin
                                w_op    = OP_PUSH;
                                w_ins   = VALUE_WIDTH'(w_sym - CH_ZERO);
                                n_depth = r_depth + DEPTH_W'(1);
                            end
                        end else if (w_sym == CH_PLUS || w_sym == CH_MINUS ||
                                     w_sym == CH_MUL || w_sym == CH_DIV) begin
                            if (r_depth < DEPTH_W'(2)) begin
                                n_err = STATUS_UNDER;
                            end else if (w_sym == CH_PLUS) begin
                                w_op    = OP_POP_REPL;
                                w_ins   = w_b + w_a;
                                n_depth = r_depth - DEPTH_W'(1);
                            end else if (w_sym == CH_MINUS) begin
                                w_op    = OP_POP_REPL;
                                w_ins   = w_b - w_a;
                                n_depth = r_depth - DEPTH_W'(1);
                            end else if (w_sym == CH_MUL) begin
                                n_state = S_MUL;
                            end else if (w_a == '0) begin
                                w_op    = OP_POP2;
                                n_depth = r_depth - DEPTH_W'(2);
                                n_err   = STATUS_DIVZERO;
                            end else begin
                                w_div_req.start = 1'b1;
                                n_state         = S_DIV;
                            end
                        end else begin
                            // other characters are ignored
                        end
                    end
                end
            end
            S_MUL: begin
                w_op    = OP_POP_REPL;
                w_ins   = VALUE_WIDTH'(w_b * w_a);
                n_depth = r_depth - DEPTH_W'(1);
                n_state = w_after;
            end
            S_DIV: begin
                if (w_div_rsp.done) begin
                    w_op    = OP_POP_REPL;
                    w_ins   = w_div_rsp.quotient;
                    n_depth = r_depth - DEPTH_W'(1);
                    n_state = w_after;
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    if (r_err != STATUS_OK) begin
                        n_out_value  = '0;
                        n_out_status = r_err;
                    end else if (r_depth == '0) begin
                        n_out_value  = '0;
                        n_out_status = STATUS_EMPTY;
                    end else begin
                        n_out_value  = w_a;
                        n_out_status = STATUS_OK;
                    end
                    n_depth = '0;
                    n_err   = STATUS_OK;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_depth     <= '0;
            r_err       <= STATUS_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_depth     <= n_depth;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
        r_last       <= n_last;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_TDATA_W'({r_out_status, r_out_value});

    // Checks
    `PFE_ASSERT_NOW(a_depth_range, i_clk, i_rst_n, 1'b1, r_depth <= DEPTH_W'(STACK_DEPTH), "stack depth out of range")
    `PFE_ASSERT_NOW(a_div_only_in_div, i_clk, i_rst_n, r_state != S_DIV, !w_div_rsp.busy && !w_div_rsp.done, "divider active outside divide state")
    `PFE_ASSERT_NEXT(a_err_result, i_clk, i_rst_n, (r_state == S_FIN) && w_out_free && (r_err != STATUS_OK), (r_out_value == '0) && (r_out_status == $past(r_err)) && r_out_valid, "error result not loaded correctly")
    `PFE_ASSERT_NEXT(a_fin_clears, i_clk, i_rst_n, (r_state == S_FIN) && w_out_free, (r_depth == '0) && (r_err == STATUS_OK) && (r_state == S_IDLE), "stack not cleared after result")

endmodule
